// ===== hdl/pep_pkg.sv =====
// Shared types and constants for the palette expander with alpha premultiply.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package pep_pkg;

	localparam int PALETTE_DEPTH = 256;
	localparam int PAL_AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

	localparam int IDX_W   = 8;
	localparam int CNT_W   = 9;
	localparam int CHAN_W  = 8;
	localparam int COLOR_W = 32;
	localparam int PROD_W  = 16;

	// Item operation codes
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_PIXEL = 1'b1;

	localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [CHAN_W-1:0] ALPHA_CLEAR  = 8'd0;
	localparam logic [PROD_W-1:0] ROUND_BIAS   = 16'd127;

	typedef struct packed {
		logic                 op;
		logic [IDX_W-1:0]     index;
		logic [COLOR_W-1:0]   entry_color;
	} in_item_t;

	typedef struct packed {
		logic [CHAN_W-1:0] out_alpha;
		logic [CHAN_W-1:0] out_red;
		logic [CHAN_W-1:0] out_green;
		logic [CHAN_W-1:0] out_blue;
	} out_item_t;

	// Stage 1 control handed to the premultiply stages
	typedef struct packed {
		logic valid;
		logic hit;
	} lookup_ctl_t;

	// Divide x by 255 for x below 65280, no divider
	function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
		logic [PROD_W-1:0] sum;
		sum = x + {8'd0, x[PROD_W-1:8]} + 16'd1;
		return sum[PROD_W-1:8];
	endfunction

endpackage

`default_nettype wire

// ===== hdl/pep_palette_ram.sv =====
// Palette storage: one write port, one read port with registered read data.
// Depends on pep_pkg for depth and widths.
`default_nettype none

module pep_palette_ram (
	input  wire logic                       clk,
	input  wire logic                       wr_en,
	input  wire logic [pep_pkg::PAL_AW-1:0] wr_addr,
	input  wire logic [pep_pkg::COLOR_W-1:0] wr_data,
	input  wire logic                       rd_en,
	input  wire logic [pep_pkg::PAL_AW-1:0] rd_addr,
	output logic      [pep_pkg::COLOR_W-1:0] rd_data
);
	import pep_pkg::*;

	logic [COLOR_W-1:0] mem [PALETTE_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/pep_premul.sv =====
// Premultiply stages: stage 2 forms c*alpha+127, stage 3 divides by 255 and
// applies the transparent and opaque cases into the output register.
// Depends on pep_pkg.
`default_nettype none

module pep_premul (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire pep_pkg::lookup_ctl_t         ctl_s1,
	input  wire logic [pep_pkg::COLOR_W-1:0]  color_s1,
	output logic                              adv_s2,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output pep_pkg::out_item_t                out_item
);
	import pep_pkg::*;

	logic              v_s2;
	logic              clear_s2;
	logic              opaque_s2;
	logic [CHAN_W-1:0] a_s2;
	logic [CHAN_W-1:0] r_s2, g_s2, b_s2;
	logic [PROD_W-1:0] pr_s2, pg_s2, pb_s2;
	logic              v_s3;
	out_item_t         item_s3;
	logic              adv_s3;

	logic [CHAN_W-1:0] a_in, r_in, g_in, b_in;

	assign a_in = color_s1[31:24];
	assign r_in = color_s1[23:16];
	assign g_in = color_s1[15:8];
	assign b_in = color_s1[7:0];

	assign adv_s3 = !v_s3 || !out_stall;
	assign adv_s2 = !v_s2 || adv_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv_s2) begin
				v_s2 <= ctl_s1.valid;
			end
			if (adv_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			clear_s2  <= !ctl_s1.hit || (a_in == ALPHA_CLEAR);
			opaque_s2 <= (a_in == ALPHA_OPAQUE);
			a_s2      <= a_in;
			r_s2      <= r_in;
			g_s2      <= g_in;
			b_s2      <= b_in;
			pr_s2     <= r_in * a_in + ROUND_BIAS;
			pg_s2     <= g_in * a_in + ROUND_BIAS;
			pb_s2     <= b_in * a_in + ROUND_BIAS;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			if (clear_s2) begin
				item_s3 <= '0;
			end else if (opaque_s2) begin
				item_s3 <= '{out_alpha: a_s2, out_red: r_s2, out_green: g_s2,
					out_blue: b_s2};
			end else begin
				item_s3 <= '{out_alpha: a_s2, out_red: div255(pr_s2),
					out_green: div255(pg_s2), out_blue: div255(pb_s2)};
			end
		end
	end

	assign out_valid = v_s3;
	assign out_item  = item_s3;

endmodule

`default_nettype wire

// ===== hdl/palette_expand_premultiply_unit.sv =====
// Palette expander with alpha premultiply, top level.
// Pixels pass the lookup, multiply and divide stages in order on the way to the result.
// Throughput: one item per cycle while out_stall is low; palette writes use the RAM
// write port and produce no result. Reset clears the pipeline valid bits and color_count;
// palette contents are undefined until written, with no clearing pass.
`default_nettype none

module palette_expand_premultiply_unit (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire pep_pkg::in_item_t           in_item,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output pep_pkg::out_item_t               out_item,
	input  wire logic                        cfg_we,
	input  wire logic [pep_pkg::CNT_W-1:0]   cfg_wdata
);
	import pep_pkg::*;

	localparam logic [CNT_W-1:0] DEPTH_LIM = CNT_W'(PALETTE_DEPTH);

	logic [CNT_W-1:0]   color_count_q;
	logic               v_s1;
	logic               hit_s1;
	logic [COLOR_W-1:0] color_s1;
	logic               adv_s1;
	logic               adv_s2;
	logic               accept;
	logic               in_store;
	logic [CNT_W-1:0]   idx_ext;
	lookup_ctl_t        ctl_s1;

	assign adv_s1   = !v_s1 || adv_s2;
	assign in_stall = !adv_s1;
	assign accept   = in_valid && adv_s1;
	assign idx_ext  = {1'b0, in_item.index};
	assign in_store = idx_ext < DEPTH_LIM;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_count_q <= '0;
		end else if (cfg_we) begin
			color_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv_s1) begin
			v_s1 <= in_valid && (in_item.op == OP_PIXEL);
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_item.op == OP_PIXEL) begin
			hit_s1 <= in_store && (idx_ext < color_count_q);
		end
	end

	pep_palette_ram u_ram (
		.clk     (clk),
		.wr_en   (accept && in_item.op == OP_WRITE && in_store),
		.wr_addr (in_item.index[PAL_AW-1:0]),
		.wr_data (in_item.entry_color),
		.rd_en   (accept && in_item.op == OP_PIXEL),
		.rd_addr (in_item.index[PAL_AW-1:0]),
		.rd_data (color_s1)
	);

	assign ctl_s1 = '{valid: v_s1, hit: hit_s1};

	pep_premul u_premul (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.color_s1  (color_s1),
		.adv_s2    (adv_s2),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

`default_nettype wire

// ===== hdl/pep_checker.sv =====
// Port-level checks for palette_expand_premultiply_unit, attached by bind.
// Depends on pep_pkg.
`default_nettype none

module pep_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_stall,
	input wire pep_pkg::in_item_t         in_item,
	input wire logic                      out_valid,
	input wire logic                      out_stall,
	input wire pep_pkg::out_item_t        out_item
);
	import pep_pkg::*;

	// A stalled input item stays offered and unchanged
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_item))
		else $error("stalled input changed");

	// A held result keeps its value until transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("stalled result changed");

	// With an empty output register the pipeline must take input
	a_no_idle_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with output empty");

	// Zero alpha means a fully transparent pixel
	a_clear_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.out_alpha == ALPHA_CLEAR |->
		out_item.out_red == 8'd0 && out_item.out_green == 8'd0 &&
		out_item.out_blue == 8'd0)
		else $error("transparent pixel carries color");

	// Premultiplied channels never exceed alpha
	a_premul_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.out_red <= out_item.out_alpha &&
		out_item.out_green <= out_item.out_alpha &&
		out_item.out_blue <= out_item.out_alpha)
		else $error("channel above alpha");

endmodule

bind palette_expand_premultiply_unit pep_checker u_pep_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_item   (in_item),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for palette_expand_premultiply_unit: palette writes and pixel indices
// go in with random gaps and output stalls; every pixel is checked against a local predictor.
// Depends on pep_pkg and the block's RTL only.

module testbench;
	import pep_pkg::*;

	localparam int CLK_HALF    = 6;
	localparam int LATENCY     = 3;
	localparam int MAX_GAP     = 10;
	localparam int LONG_HOLD   = 300;
	localparam int PHASE_ITEMS = 190;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic             in_stall;
	in_item_t         in_item   = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	out_item_t        out_item;
	logic             cfg_we    = 1'b0;
	logic [CNT_W-1:0] cfg_wdata = '0;

	// Shadow of the block's palette and color count
	logic [COLOR_W-1:0] pal_shadow [PALETTE_DEPTH];
	bit                 pal_written [PALETTE_DEPTH];
	logic [CNT_W-1:0]   count_shadow = '0;
	out_item_t          pixel_expected [$];
	out_item_t          pixel_want;

	int mismatch_count = 0;
	bit src_idle       = 1'b0;
	bit sink_idle      = 1'b0;
	int sink_hold      = 0;

	palette_expand_premultiply_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic logic [CHAN_W-1:0] scale_channel(input logic [CHAN_W-1:0] c,
			input logic [CHAN_W-1:0] a);
		int unsigned cw;
		int unsigned aw;
		cw = 32'(c);
		aw = 32'(a);
		return CHAN_W'((cw * aw + 127) / 255);
	endfunction

	function automatic out_item_t expand_pixel(input logic [IDX_W-1:0] idx);
		out_item_t          px;
		logic [COLOR_W-1:0] e;
		px = '0;
		if ({1'b0, idx} < count_shadow) begin
			e = pal_shadow[idx];
			px.out_alpha = e[31:24];
			px.out_red   = e[23:16];
			px.out_green = e[15:8];
			px.out_blue  = e[7:0];
			if (px.out_alpha == ALPHA_CLEAR) begin
				px.out_red   = '0;
				px.out_green = '0;
				px.out_blue  = '0;
			end else if (px.out_alpha != ALPHA_OPAQUE) begin
				px.out_red   = scale_channel(px.out_red, px.out_alpha);
				px.out_green = scale_channel(px.out_green, px.out_alpha);
				px.out_blue  = scale_channel(px.out_blue, px.out_alpha);
			end
		end
		return px;
	endfunction

	function automatic in_item_t palette_write(input logic [IDX_W-1:0] idx,
			input logic [COLOR_W-1:0] color);
		in_item_t item;
		item.op          = OP_WRITE;
		item.index       = idx;
		item.entry_color = color;
		return item;
	endfunction

	function automatic in_item_t pixel_at(input logic [IDX_W-1:0] idx);
		in_item_t item;
		item.op          = OP_PIXEL;
		item.index       = idx;
		item.entry_color = $urandom;
		return item;
	endfunction

	function automatic logic [COLOR_W-1:0] rand_color();
		logic [COLOR_W-1:0] c;
		c = $urandom;
		case ($urandom_range(0, 7))
			0: c[31:24] = ALPHA_CLEAR;
			1: c[31:24] = ALPHA_OPAQUE;
			2: c[23:0] = 24'hFFFFFF;
			3: c[23:0] = '0;
			default: ;
		endcase
		return c;
	endfunction

	// Never point at an entry below the count that has not been written
	function automatic logic [IDX_W-1:0] rand_pixel_index();
		logic [IDX_W-1:0] idx;
		idx = IDX_W'($urandom_range(0, 255));
		if ($urandom_range(0, 7) == 0 && count_shadow != 0 && count_shadow <= 256)
			idx = IDX_W'(count_shadow - 1 + $urandom_range(0, 1));
		while ({1'b0, idx} < count_shadow && !pal_written[idx])
			idx = IDX_W'($urandom_range(0, 255));
		return idx;
	endfunction

	task automatic report_mismatch(input string msg);
		mismatch_count++;
		$display("mismatch: %s", msg);
	endtask

	task automatic send_item(input in_item_t item);
		int gap;
		gap = src_idle ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			@(negedge clk);
			in_valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_item  = item;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		// Transfer done: update the shadow state
		if (item.op == OP_WRITE) begin
			pal_shadow[item.index]  = item.entry_color;
			pal_written[item.index] = 1'b1;
		end else begin
			pixel_expected.push_back(expand_pixel(item.index));
		end
	endtask

	task automatic wait_pipeline_empty();
		@(negedge clk);
		in_valid = 1'b0;
		while (pixel_expected.size() != 0) @(posedge clk);
		// Writes give no result and may still be in flight
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic set_color_count(input logic [CNT_W-1:0] value);
		wait_pipeline_empty();
		@(negedge clk);
		cfg_we       = 1'b1;
		cfg_wdata    = value;
		count_shadow = value;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic test_reset_count();
		src_idle  = 1'b0;
		sink_idle = 1'b0;
		send_item(pixel_at(8'd0));
		send_item(pixel_at(8'd255));
		send_item(pixel_at(8'hAA));
	endtask

	task automatic test_alpha_cases();
		send_item(palette_write(8'd0, 32'hFF123456));
		send_item(palette_write(8'd255, 32'h00FFFFFF));
		send_item(palette_write(8'd1, 32'h01FFFFFF));
		send_item(palette_write(8'd2, 32'h80FF8001));
		send_item(palette_write(8'd3, 32'hFE00FF7F));
		set_color_count(9'd256);
		send_item(pixel_at(8'd0));
		send_item(pixel_at(8'd255));
		send_item(pixel_at(8'd1));
		send_item(pixel_at(8'd2));
		send_item(pixel_at(8'd3));
		// Read an entry right behind its write
		send_item(palette_write(8'd4, 32'h7F102030));
		send_item(pixel_at(8'd4));
		send_item(palette_write(8'd4, 32'hFFFFFFFF));
		send_item(pixel_at(8'd4));
	endtask

	task automatic test_count_limit();
		set_color_count(9'd3);
		send_item(pixel_at(8'd2));
		send_item(pixel_at(8'd3));
		send_item(pixel_at(8'd255));
		// Count above the index range: every index valid
		set_color_count(9'd511);
		send_item(pixel_at(8'd255));
		send_item(pixel_at(8'd0));
	endtask

	task automatic test_output_backpressure();
		wait_pipeline_empty();
		src_idle  = 1'b0;
		sink_hold = LONG_HOLD;
		repeat (40) send_item(pixel_at(rand_pixel_index()));
		wait_pipeline_empty();
	endtask

	task automatic test_random_traffic();
		logic [CNT_W-1:0] counts [8];
		counts[0] = 9'd256;
		counts[1] = 9'd1;
		counts[2] = 9'd0;
		counts[3] = 9'd511;
		counts[4] = 9'd255;
		counts[5] = CNT_W'($urandom_range(2, 254));
		counts[6] = 9'd128;
		counts[7] = 9'd300;
		src_idle  = 1'b1;
		sink_idle = 1'b1;
		for (int i = 0; i < PALETTE_DEPTH; i++)
			send_item(palette_write(i[IDX_W-1:0], rand_color()));
		foreach (counts[p]) begin
			set_color_count(counts[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 40 == 0) begin
					src_idle  = 1'($urandom_range(0, 1));
					sink_idle = 1'($urandom_range(0, 1));
				end
				if ($urandom_range(0, 4) == 0)
					send_item(palette_write(IDX_W'($urandom_range(0, 255)),
						rand_color()));
				else
					send_item(pixel_at(rand_pixel_index()));
				if ($urandom_range(0, 149) == 0)
					wait_pipeline_empty();
			end
		end
	endtask

	initial begin : result_sink
		int hold;
		wait (arst_n === 1'b1);
		forever begin
			hold = sink_idle ? $urandom_range(0, MAX_GAP) : 0;
			if (sink_hold > 0) begin
				hold      = sink_hold;
				sink_hold = 0;
			end
			if (hold > 0) begin
				@(negedge clk);
				out_stall = 1'b1;
				repeat (hold - 1) @(negedge clk);
			end
			@(negedge clk);
			out_stall = 1'b0;
			// Wait for one transfer
			@(posedge clk);
			while (!out_valid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pixel_expected.size() == 0) begin
				report_mismatch($sformatf("pixel %h with none expected", out_item));
			end else begin
				pixel_want = pixel_expected.pop_front();
				if (out_item.out_alpha !== pixel_want.out_alpha)
					report_mismatch($sformatf("alpha %h, want %h",
						out_item.out_alpha, pixel_want.out_alpha));
				if (out_item.out_red !== pixel_want.out_red)
					report_mismatch($sformatf("red %h, want %h",
						out_item.out_red, pixel_want.out_red));
				if (out_item.out_green !== pixel_want.out_green)
					report_mismatch($sformatf("green %h, want %h",
						out_item.out_green, pixel_want.out_green));
				if (out_item.out_blue !== pixel_want.out_blue)
					report_mismatch($sformatf("blue %h, want %h",
						out_item.out_blue, pixel_want.out_blue));
			end
		end
	end

	initial begin : run
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		test_reset_count();
		test_alpha_cases();
		test_count_limit();
		test_output_backpressure();
		test_random_traffic();
		wait_pipeline_empty();
		repeat (LATENCY * 4) @(posedge clk);
		if (mismatch_count == 0 && pixel_expected.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin : watchdog
		#(2 * CLK_HALF * 400000);
		$display("FAILURE");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/pep_pkg.sv
hdl/pep_palette_ram.sv
hdl/pep_premul.sv
hdl/palette_expand_premultiply_unit.sv
hdl/pep_checker.sv
tb/testbench.sv
